// ----- rtl/core/cgqve_pkg.sv -----
`default_nettype none

package cgqve_pkg;

  localparam int GroupsPerBlock = 10;
  localparam int GposWidth = 4;
  localparam int MaxCodes = 15;
  localparam int NumLanes = 4;

  localparam int NumSlots = 8;
  localparam logic [2:0] SlotDc = 3'd0;
  localparam logic [2:0] SlotZero = 3'd1;
  localparam logic [2:0] SlotPat = 3'd2;
  localparam logic [2:0] SlotLvA = 3'd3;
  localparam logic [2:0] SlotLvB = 3'd4;
  localparam logic [2:0] SlotLvC = 3'd5;
  localparam logic [2:0] SlotLvD = 3'd6;
  localparam logic [2:0] SlotEob = 3'd7;

  typedef struct packed {
    logic [10:0] bits;
    logic [3:0]  len;
  } code_t;

  localparam code_t CodeZeroGroup = '{bits: 11'h002, len: 4'd2};
  localparam code_t CodeEob = '{bits: 11'h00F, len: 4'd5};
  localparam logic [3:0] EscapeLen = 4'd11;

  typedef struct packed {
    logic [NumSlots-1:0]  mask;
    logic [3:0]           zeros;
    logic                 pat_nz;
    code_t                pat;
    code_t [NumLanes-1:0] lv;
  } plan_t;

  function automatic code_t pat_code(input logic [3:0] pat);
    code_t c;
    c.len = 4'd5;
    case (pat)
      4'd0:  begin c.bits = 11'h002; c.len = 4'd2; end
      4'd1:  c.bits = 11'h007;
      4'd2:  c.bits = 11'h00B;
      4'd3:  c.bits = 11'h003;
      4'd4:  c.bits = 11'h00D;
      4'd5:  c.bits = 11'h005;
      4'd6:  c.bits = 11'h009;
      4'd7:  c.bits = 11'h001;
      4'd8:  c.bits = 11'h00E;
      4'd9:  c.bits = 11'h006;
      4'd10: c.bits = 11'h00A;
      4'd11: c.bits = 11'h002;
      4'd12: c.bits = 11'h00C;
      4'd13: c.bits = 11'h004;
      4'd14: c.bits = 11'h008;
      4'd15: begin c.bits = 11'h003; c.len = 4'd2; end
      default: c.bits = 11'h000;
    endcase
    return c;
  endfunction

  function automatic code_t lvl_code(input logic signed [15:0] lv);
    code_t c;
    case (lv)
      -16'sd3: begin c.bits = 11'd3; c.len = 4'd4; end
      -16'sd2: begin c.bits = 11'd3; c.len = 4'd3; end
      -16'sd1: begin c.bits = 11'd3; c.len = 4'd2; end
      16'sd0:  begin c.bits = 11'd0; c.len = 4'd3; end
      16'sd1:  begin c.bits = 11'd2; c.len = 4'd2; end
      16'sd2:  begin c.bits = 11'd2; c.len = 4'd3; end
      16'sd3:  begin c.bits = 11'd2; c.len = 4'd4; end
      default: begin c.bits = {3'b000, lv[7:0]}; c.len = EscapeLen; end
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/cgqve_if.sv -----
`default_nettype none

interface cgqve_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] dc_value;
  logic signed [15:0] coef_a;
  logic signed [15:0] coef_b;
  logic signed [15:0] coef_c;
  logic signed [15:0] coef_d;
  logic [15:0]        recip_a;
  logic [15:0]        recip_b;
  logic [15:0]        recip_c;
  logic [15:0]        recip_d;

  modport source (
    output valid, dc_value, coef_a, coef_b, coef_c, coef_d,
    output recip_a, recip_b, recip_c, recip_d,
    input  ready
  );
  modport sink (
    input  valid, dc_value, coef_a, coef_b, coef_c, coef_d,
    input  recip_a, recip_b, recip_c, recip_d,
    output ready
  );
endinterface

interface cgqve_out_if;
  logic        valid;
  logic        ready;
  logic [10:0] code_bits;
  logic [3:0]  code_length;
  logic        last_of_item;

  modport source (output valid, code_bits, code_length, last_of_item, input ready);
  modport sink (input valid, code_bits, code_length, last_of_item, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/coeff_group_quant_vlc_encoder_unit.sv -----
// Flow: an accepted group beat is registered in the lanes, planned in the quantize
// state, and its N codewords (0..15) then leave through the single output register,
// one codeword per cycle while the output is free; no new group is taken until idle.
// Reset (rst_ni low, asynchronous): group position and pending zero count clear,
// the output register empties, and the unit returns to idle.
`default_nettype none

module coeff_group_quant_vlc_encoder_unit import cgqve_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  cgqve_in_if.sink     in_i,
  cgqve_out_if.source  out_o
);

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StQuant = 2'd1;
  localparam logic [1:0] StEmit  = 2'd2;

  logic [1:0]           state_q, state_d;
  logic [GposWidth-1:0] gpos_q, gpos_d;
  logic [3:0]           pending_q, pending_d;
  logic                 first_q, last_q;
  logic [7:0]           dc_q;
  logic [NumSlots-1:0]  mask_q, mask_d;
  logic [3:0]           zeros_q, zeros_d;
  code_t                pat_q;
  code_t [NumLanes-1:0] lv_q;
  logic                 ovalid_q, ovalid_d;
  code_t                ocode_q;
  logic                 olast_q;

  logic                 in_fire, out_free, load_out;
  logic                 first_d, last_d;
  logic signed [16:0]   dc_sum;
  logic signed [15:0]   level [NumLanes];
  plan_t                plan;
  logic [2:0]           slot;
  code_t                cur_code;
  logic [NumSlots-1:0]  rem;
  logic                 cur_final;

  assign in_i.ready = (state_q == StIdle);
  assign in_fire    = in_i.valid && in_i.ready;
  assign out_free   = !ovalid_q || out_o.ready;

  assign first_d = (gpos_q == '0);
  assign last_d  = ({1'b0, gpos_q} + 5'd1) >= 5'(GroupsPerBlock);
  assign dc_sum  = 17'(in_i.dc_value) + 17'sd32;

  cgqve_lane u_lane_a (.clk_i, .en_i(in_fire), .coef_i(in_i.coef_a),
                       .recip_i(in_i.recip_a), .level_o(level[0]));
  cgqve_lane u_lane_b (.clk_i, .en_i(in_fire), .coef_i(in_i.coef_b),
                       .recip_i(in_i.recip_b), .level_o(level[1]));
  cgqve_lane u_lane_c (.clk_i, .en_i(in_fire), .coef_i(in_i.coef_c),
                       .recip_i(in_i.recip_c), .level_o(level[2]));
  cgqve_lane u_lane_d (.clk_i, .en_i(in_fire), .coef_i(in_i.coef_d),
                       .recip_i(in_i.recip_d), .level_o(level[3]));

  cgqve_merge u_merge (
    .level_i  (level),
    .first_i  (first_q),
    .last_i   (last_q),
    .pending_i(pending_q),
    .plan_o   (plan)
  );

  always_comb begin
    slot = SlotEob;
    for (int i = NumSlots - 1; i >= 0; i--) begin
      if (mask_q[i]) begin
        slot = 3'(i);
      end
    end
    case (slot)
      SlotDc:   cur_code = '{bits: {3'b000, dc_q}, len: 4'd8};
      SlotZero: cur_code = CodeZeroGroup;
      SlotPat:  cur_code = pat_q;
      SlotLvA:  cur_code = lv_q[0];
      SlotLvB:  cur_code = lv_q[1];
      SlotLvC:  cur_code = lv_q[2];
      SlotLvD:  cur_code = lv_q[3];
      SlotEob:  cur_code = CodeEob;
      default:  cur_code = CodeEob;
    endcase
    rem = mask_q & ~(NumSlots'(1) << slot);
    if ((slot == SlotZero) && (zeros_q != 4'd1)) begin
      rem[SlotZero] = 1'b1;
    end
    cur_final = (rem == '0);
  end

  assign load_out = (state_q == StEmit) && out_free;

  always_comb begin
    state_d   = state_q;
    gpos_d    = gpos_q;
    pending_d = pending_q;
    mask_d    = mask_q;
    zeros_d   = zeros_q;
    ovalid_d  = ovalid_q;
    if (out_o.ready) begin
      ovalid_d = 1'b0;
    end
    case (state_q)
      StIdle: begin
        if (in_fire) begin
          state_d = StQuant;
        end
      end
      StQuant: begin
        mask_d  = plan.mask;
        zeros_d = plan.zeros;
        if (plan.pat_nz) begin
          pending_d = '0;
        end else if (pending_q != 4'd15) begin
          pending_d = pending_q + 4'd1;
        end
        if (last_q) begin
          gpos_d    = '0;
          pending_d = '0;
        end else begin
          gpos_d = gpos_q + GposWidth'(1);
        end
        state_d = (plan.mask == '0) ? StIdle : StEmit;
      end
      StEmit: begin
        if (load_out) begin
          ovalid_d = 1'b1;
          mask_d   = rem;
          if (slot == SlotZero) begin
            zeros_d = zeros_q - 4'd1;
          end
          if (cur_final) begin
            state_d = StIdle;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      gpos_q    <= '0;
      pending_q <= '0;
      mask_q    <= '0;
      zeros_q   <= '0;
      ovalid_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      gpos_q    <= gpos_d;
      pending_q <= pending_d;
      mask_q    <= mask_d;
      zeros_q   <= zeros_d;
      ovalid_q  <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      first_q <= first_d;
      last_q  <= last_d;
      dc_q    <= dc_sum[13:6];
    end
    if (state_q == StQuant) begin
      pat_q <= plan.pat;
      lv_q  <= plan.lv;
    end
    if (load_out) begin
      ocode_q <= cur_code;
      olast_q <= cur_final;
    end
  end

  assign out_o.valid        = ovalid_q;
  assign out_o.code_bits    = ocode_q.bits;
  assign out_o.code_length  = ocode_q.len;
  assign out_o.last_of_item = olast_q;

  a_accept_to_quant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q == StQuant))
    else $error("accepted group did not enter quantization");

  a_gpos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    gpos_q < GposWidth'(GroupsPerBlock))
    else $error("group position beyond block");

  a_emit_has_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StEmit) |-> (mask_q != '0))
    else $error("emit state with no codeword left");

  a_block_start_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (gpos_q == '0) |-> (pending_q == '0))
    else $error("pending zero groups carried across block boundary");

endmodule

`default_nettype wire

// ----- rtl/core/cgqve_lane.sv -----
`default_nettype none

module cgqve_lane (
  input  wire logic               clk_i,
  input  wire logic               en_i,
  input  wire logic signed [15:0] coef_i,
  input  wire logic [15:0]        recip_i,
  output logic signed [15:0]      level_o
);

  logic signed [32:0] prod;
  logic signed [33:0] sum;
  logic signed [15:0] level_q;

  assign prod = coef_i * $signed({1'b0, recip_i});
  assign sum  = 34'(prod) + 34'sd32768;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      level_q <= sum[31:16];
    end
  end

  assign level_o = level_q;

endmodule

`default_nettype wire

// ----- rtl/core/cgqve_merge.sv -----
`default_nettype none

module cgqve_merge import cgqve_pkg::*; (
  input  wire logic signed [15:0] level_i [NumLanes],
  input  wire logic               first_i,
  input  wire logic               last_i,
  input  wire logic [3:0]         pending_i,
  output plan_t                   plan_o
);

  logic [NumLanes-1:0] nz;
  logic [3:0]          pat;
  logic [2:0]          nz_cnt;
  logic [4:0]          room;
  logic [3:0]          zeros;

  always_comb begin
    for (int i = 0; i < NumLanes; i++) begin
      nz[i] = (level_i[i] != 16'sd0);
    end
    if (first_i) begin
      nz[0] = 1'b0;
    end
    pat    = {nz[0], nz[1], nz[2], nz[3]};
    nz_cnt = 3'(nz[0]) + 3'(nz[1]) + 3'(nz[2]) + 3'(nz[3]);
    room   = 5'(MaxCodes) - 5'(first_i) - 5'd1 - 5'(nz_cnt) - 5'(last_i);
    zeros  = ({1'b0, pending_i} < room) ? pending_i : room[3:0];

    plan_o.pat_nz = (pat != 4'd0);
    plan_o.zeros  = plan_o.pat_nz ? zeros : 4'd0;
    plan_o.pat    = pat_code(pat);
    for (int i = 0; i < NumLanes; i++) begin
      plan_o.lv[i] = lvl_code(level_i[i]);
    end
    plan_o.mask           = '0;
    plan_o.mask[SlotDc]   = first_i;
    plan_o.mask[SlotZero] = plan_o.pat_nz && (zeros != 4'd0);
    plan_o.mask[SlotPat]  = plan_o.pat_nz;
    plan_o.mask[SlotLvA]  = nz[0];
    plan_o.mask[SlotLvB]  = nz[1];
    plan_o.mask[SlotLvC]  = nz[2];
    plan_o.mask[SlotLvD]  = nz[3];
    plan_o.mask[SlotEob]  = last_i;
  end

endmodule

`default_nettype wire

// ----- tb/sv/cgqve_checker.sv -----
`timescale 1ns / 100ps

module cgqve_checker import cgqve_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  cgqve_in_if   in_i,
  cgqve_out_if  out_i,
  output int    fail_count_o,
  output int    outstanding_o,
  output int    groups_o,
  output int    codes_o,
  output int    escapes_o,
  output int    flushed_zero_groups_o
);

  typedef struct packed {
    logic [10:0] bits;
    logic [3:0]  len;
    logic        last;
  } codeword_t;

  localparam logic [3:0] DcLen = 4'd8;
  localparam longint DcRound = 32;
  localparam int DcShift = 6;
  localparam longint RoundHalf = 32768;
  localparam int FracBits = 16;
  localparam logic [3:0] ZeroRunMax = 4'd15;

  localparam logic [10:0] PatBits [16] = '{
    11'h002, 11'h007, 11'h00B, 11'h003, 11'h00D, 11'h005, 11'h009, 11'h001,
    11'h00E, 11'h006, 11'h00A, 11'h002, 11'h00C, 11'h004, 11'h008, 11'h003
  };
  localparam logic [3:0] PatLen [16] = '{
    4'd2, 4'd5, 4'd5, 4'd5, 4'd5, 4'd5, 4'd5, 4'd5,
    4'd5, 4'd5, 4'd5, 4'd5, 4'd5, 4'd5, 4'd5, 4'd2
  };
  localparam logic [10:0] LvlBits [7] = '{11'd3, 11'd3, 11'd3, 11'd0, 11'd2, 11'd2, 11'd2};
  localparam logic [3:0] LvlLen [7] = '{4'd4, 4'd3, 4'd2, 4'd3, 4'd2, 4'd3, 4'd4};

  logic [3:0] group_pos;
  logic [3:0] zero_run;
  codeword_t  expected_codes[$];
  codeword_t  want;

  function automatic logic signed [15:0] quant_level(input logic signed [15:0] coef,
                                                     input logic [15:0] recip);
    longint prod;
    prod = longint'(coef) * longint'(recip) + RoundHalf;
    return 16'(prod >>> FracBits);
  endfunction

  function automatic void emit(inout codeword_t q[$], input logic [10:0] bits,
                               input logic [3:0] len);
    if (q.size() < MaxCodes) q.push_back('{bits: bits, len: len, last: 1'b0});
  endfunction

  function automatic void encode_group();
    logic signed [15:0] coefs [4];
    logic [15:0]        recips [4];
    logic signed [15:0] lv [4];
    codeword_t          q[$];
    logic [3:0]         pat;
    bit                 first;
    bit                 last;
    int                 nz;
    int                 room;
    int                 zeros;
    int                 idx;
    longint             dc;
    coefs = '{in_i.coef_a, in_i.coef_b, in_i.coef_c, in_i.coef_d};
    recips = '{in_i.recip_a, in_i.recip_b, in_i.recip_c, in_i.recip_d};
    first = (group_pos == 0);
    last = (int'(group_pos) + 1 >= GroupsPerBlock);
    pat = '0;
    nz = 0;
    if (first) begin
      dc = longint'(in_i.dc_value) + DcRound;
      emit(q, 11'((dc >>> DcShift) & 255), DcLen);
    end
    for (int i = 0; i < 4; i++) lv[i] = quant_level(coefs[i], recips[i]);
    if (first) lv[0] = '0;
    for (int i = 0; i < 4; i++) begin
      if (lv[i] != 0) begin
        pat[3-i] = 1'b1;
        nz++;
      end
    end
    if (pat != 0) begin
      room = MaxCodes - q.size() - 1 - nz - (last ? 1 : 0);
      zeros = (int'(zero_run) < room) ? int'(zero_run) : room;
      flushed_zero_groups_o += zeros;
      for (int k = 0; k < zeros; k++) emit(q, CodeZeroGroup.bits, CodeZeroGroup.len);
      zero_run = '0;
      emit(q, PatBits[pat], PatLen[pat]);
      for (int i = 0; i < 4; i++) begin
        if (lv[i] != 0) begin
          idx = int'(lv[i]) + 3;
          if (idx >= 0 && idx <= 6) begin
            emit(q, LvlBits[idx], LvlLen[idx]);
          end else begin
            emit(q, {3'b000, lv[i][7:0]}, EscapeLen);
            escapes_o++;
          end
        end
      end
    end else if (zero_run < ZeroRunMax) begin
      zero_run++;
    end
    if (last) begin
      emit(q, CodeEob.bits, CodeEob.len);
      group_pos = '0;
      zero_run = '0;
    end else begin
      group_pos = group_pos + 4'd1;
    end
    if (q.size() > 0) q[q.size()-1].last = 1'b1;
    foreach (q[i]) expected_codes.push_back(q[i]);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      group_pos = '0;
      zero_run = '0;
      expected_codes.delete();
      fail_count_o = 0;
      outstanding_o = 0;
      groups_o = 0;
      codes_o = 0;
      escapes_o = 0;
      flushed_zero_groups_o = 0;
    end else begin
      if (in_i.valid && in_i.ready) begin
        encode_group();
        groups_o++;
      end
      if (out_i.valid && out_i.ready) begin
        codes_o++;
        if (expected_codes.size() == 0) begin
          $error("codeword beat with nothing expected: bits %0h, length %0d",
                 out_i.code_bits, out_i.code_length);
          fail_count_o++;
        end else begin
          want = expected_codes.pop_front();
          if (out_i.code_bits !== want.bits) begin
            $error("code_bits: expected %0h, actual %0h", want.bits, out_i.code_bits);
            fail_count_o++;
          end
          if (out_i.code_length !== want.len) begin
            $error("code_length: expected %0d, actual %0d", want.len, out_i.code_length);
            fail_count_o++;
          end
          if (out_i.last_of_item !== want.last) begin
            $error("last_of_item: expected %0b, actual %0b", want.last, out_i.last_of_item);
            fail_count_o++;
          end
        end
      end
      outstanding_o = expected_codes.size();
    end
  end

endmodule

// ----- tb/sv/tb_coeff_group_quant_vlc_encoder_unit.sv -----
`timescale 1ns / 100ps

module tb_coeff_group_quant_vlc_encoder_unit import cgqve_pkg::*; ();

  localparam int RandomGroups = 350;
  localparam int StallLimit = 5000;
  localparam int TailCycles = 20;
  localparam logic [15:0] HalfRecip = 16'h8000;

  logic clk_i;
  logic rst_ni;
  int   send_idle_pct;
  int   recv_idle_pct;
  int   quiet_cycles;
  int   fail_count;
  int   outstanding;
  int   groups_seen;
  int   codes_seen;
  int   escapes_seen;
  int   flushed_seen;

  cgqve_in_if  in_if ();
  cgqve_out_if out_if ();

  coeff_group_quant_vlc_encoder_unit u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  cgqve_checker u_checker (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .in_i                  (in_if),
    .out_i                 (out_if),
    .fail_count_o          (fail_count),
    .outstanding_o         (outstanding),
    .groups_o              (groups_seen),
    .codes_o               (codes_seen),
    .escapes_o             (escapes_seen),
    .flushed_zero_groups_o (flushed_seen)
  );

  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(negedge clk_i) begin
    out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
        $display("tb_coeff_group_quant_vlc_encoder_unit failed");
        $finish;
      end
    end
  end

  task automatic put_group(input logic signed [15:0] dc, input logic signed [15:0] a,
                           input logic signed [15:0] b, input logic signed [15:0] c,
                           input logic signed [15:0] d, input logic [15:0] ra,
                           input logic [15:0] rb, input logic [15:0] rc,
                           input logic [15:0] rd);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.dc_value <= dc;
    in_if.coef_a <= a;
    in_if.coef_b <= b;
    in_if.coef_c <= c;
    in_if.coef_d <= d;
    in_if.recip_a <= ra;
    in_if.recip_b <= rb;
    in_if.recip_c <= rc;
    in_if.recip_d <= rd;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // a half reciprocal turns coefficient 2L into level L
  task automatic put_levels(input logic signed [15:0] dc, input int la, input int lb,
                            input int lc, input int ld);
    put_group(dc, 16'(2 * la), 16'(2 * lb), 16'(2 * lc), 16'(2 * ld),
              HalfRecip, HalfRecip, HalfRecip, HalfRecip);
  endtask

  task automatic rand_coef(output logic signed [15:0] coef, output logic [15:0] recip,
                           input bit all_zero);
    int pick;
    int lv;
    pick = all_zero ? 0 : $urandom_range(99);
    if (pick < 35) begin
      if ($urandom_range(1)) begin
        coef = '0;
        recip = 16'($urandom);
      end else begin
        coef = 16'($urandom);
        recip = '0;
      end
    end else if (pick < 75) begin
      lv = $urandom_range(6) - 3;
      coef = 16'(2 * lv);
      recip = HalfRecip;
    end else if (pick < 90) begin
      coef = 16'($urandom);
      recip = 16'($urandom);
    end else begin
      lv = $urandom_range(200, 4);
      if ($urandom_range(1)) lv = -lv;
      coef = 16'(2 * lv);
      recip = HalfRecip;
    end
  endtask

  task automatic put_random_group();
    logic signed [15:0] c [4];
    logic [15:0]        r [4];
    bit                 all_zero;
    all_zero = ($urandom_range(99) < 25);
    for (int i = 0; i < 4; i++) rand_coef(c[i], r[i], all_zero);
    put_group(16'($urandom), c[0], c[1], c[2], c[3], r[0], r[1], r[2], r[3]);
  endtask

  initial begin
    rst_ni = 1'b0;
    send_idle_pct = 16;
    recv_idle_pct = 84;
    quiet_cycles = 0;
    in_if.valid = 1'b0;
    in_if.dc_value = '0;
    in_if.coef_a = '0;
    in_if.coef_b = '0;
    in_if.coef_c = '0;
    in_if.coef_d = '0;
    in_if.recip_a = '0;
    in_if.recip_b = '0;
    in_if.recip_c = '0;
    in_if.recip_d = '0;
    out_if.ready = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // first block: DC extreme, forced-zero first coefficient, every short level, escapes
    put_group(-16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767, 16'sd0,
              16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    put_levels(16'sd0, -3, -2, -1, 1);
    put_levels(16'sd0, 2, 3, 0, 0);
    put_levels(16'sd0, 0, 0, 0, 0);
    put_levels(16'sd0, 0, 0, 0, 0);
    put_levels(16'sd0, 0, 0, 0, -3);
    put_group(16'sd0, -16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767,
              16'h0000, 16'h0000, 16'h0000, 16'h0000);
    put_levels(16'sd0, 4, -4, 127, -128);
    put_levels(16'sd0, 0, 5, 0, 0);
    put_levels(-16'sd1, 0, 0, 0, 0);
    // second block: DC only, nine zero groups flushed by the last group
    put_levels(16'sd32767, 0, 0, 0, 0);
    for (int g = 1; g < GroupsPerBlock - 1; g++) put_levels(-16'sd33, 0, 0, 0, 0);
    put_levels(16'sd31, 1, 0, 0, -1);

    for (int n = 0; n < RandomGroups; n++) begin
      if (n == RandomGroups / 3) begin
        send_idle_pct = 84;
        recv_idle_pct = 16;
      end else if (n == 2 * RandomGroups / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      put_random_group();
    end
    in_if.valid <= 1'b0;

    while (outstanding != 0) @(negedge clk_i);
    repeat (TailCycles) @(negedge clk_i);

    $display("covered %0d groups (%0d blocks), %0d codewords checked", groups_seen,
             groups_seen / GroupsPerBlock, codes_seen);
    $display("escape levels: %0d, zero groups flushed: %0d", escapes_seen, flushed_seen);
    if (fail_count == 0) begin
      $display("tb_coeff_group_quant_vlc_encoder_unit passed");
    end else begin
      $display("tb_coeff_group_quant_vlc_encoder_unit failed");
    end
    $finish;
  end

endmodule
